>>> rtl/sha1_message_digest_assert.svh
// Assertion macros for the SHA-1 digest RTL.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SHA1MD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/sha1md_pkg.sv
// Package with the SHA-1 constants and the working-word type.
`default_nettype none

package sha1md_pkg;

  localparam int ROUNDS = 80;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Working words a through e of the compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } round_words_t;

endpackage

`default_nettype wire

>>> rtl/sha1_message_digest.sv
// Top level of the byte-serial SHA-1 message digest engine.
// Usage: message bytes arrive on the slave stream, one beat per item. s_tdata carries the
// byte, s_tuser says whether the byte is valid, and s_tlast closes the message after the
// beat (a beat with s_tuser low and s_tlast high closes it with no byte, so an empty
// message works). The five digest words h0..h4 leave on the master stream, h0 first,
// with m_tlast on h4, one word per cycle while m_tready is high.
// Input: a byte that does not complete a 64-byte block is taken while idle. The byte that
// completes a block starts a compression (80 rounds through the single round unit, then
// an add into the chaining words), during which s_tready is low.
// On close, the sequencer feeds the 0x80 marker, zero fill and the 8-byte bit length byte
// by byte into the block buffer, compressing once or twice, and then queues the digest.
// No new input is taken while the close sequence or a compression is running.
// Output: the digest is copied into a five-word output buffer, so the next message can be
// taken while the receiver is still draining. If the buffer has not drained when the
// next digest is ready, the block waits before copying it.
// Reset: rst is synchronous and active high; it restores the initial chaining values,
// clears the byte count and empties the output buffer.
`default_nettype none

module sha1_message_digest import sha1md_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast    // word_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_PADZ  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

  logic [2:0]   state;
  logic [2:0]   ret_state;
  logic [6:0]   round_idx;
  logic [5:0]   fill_pos;
  logic [60:0]  byte_count;
  logic         len_arm;
  logic [2:0]   out_left;
  logic [31:0]  chain [5];
  logic [31:0]  obuf [5];
  logic [511:0] win;
  round_words_t work;
  round_words_t work_next;

  logic [31:0]  w_sched;
  logic [31:0]  w_sched_raw;
  logic [63:0]  len_bits;
  logic [7:0]   len_byte;
  round_words_t chain_words;

  // The block buffer is a 512-bit shift line: bytes shift in at the bottom while filling,
  // and words shift out of the top while rounds run, so word 0 is always the current W.
  assign w_sched  = {w_sched_raw[30:0], w_sched_raw[31]};
  assign w_sched_raw = win[95:64] ^ win[255:224] ^ win[447:416] ^ win[511:480];

  assign len_bits = {byte_count, 3'b000};
  assign len_byte = len_bits[{~fill_pos[2:0], 3'b000} +: 8];

  assign chain_words = '{a: chain[0], b: chain[1], c: chain[2], d: chain[3], e: chain[4]};

  sha1md_round u_round (
    .cur       (work),
    .w         (win[511:480]),
    .round_idx (round_idx),
    .nxt       (work_next)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (out_left != 3'd0);
  assign m_tlast  = (out_left == 3'd1);
  assign m_tdata  = obuf[0];

  // Payload registers: block buffer, working words and output buffer.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tuser) begin
          win <= {win[503:0], s_tdata};
        end
      end
      S_PAD80: begin
        win <= {win[503:0], PAD_BYTE};
      end
      S_PADZ: begin
        if (!(len_arm && fill_pos == 6'd56)) begin
          win <= {win[503:0], 8'h00};
        end
      end
      S_LEN: begin
        win <= {win[503:0], len_byte};
      end
      S_ROUND: begin
        win  <= {win[479:0], w_sched};
        work <= work_next;
      end
      default: begin
      end
    endcase
    // Load the working words from the chaining words as a compression starts.
    if (state != S_ROUND) begin
      work <= chain_words;
    end
    if (state == S_OUT && out_left == 3'd0) begin
      for (int i = 0; i < 5; i++) begin
        obuf[i] <= chain[i];
      end
    end else if (m_tvalid && m_tready) begin
      for (int i = 0; i < 4; i++) begin
        obuf[i] <= obuf[i + 1];
      end
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret_state  <= S_IDLE;
      round_idx  <= 7'd0;
      fill_pos   <= 6'd0;
      byte_count <= 61'd0;
      len_arm    <= 1'b0;
      out_left   <= 3'd0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= H_INIT[i];
      end
    end else begin
      if (m_tvalid && m_tready) begin
        out_left <= out_left - 3'd1;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              byte_count <= byte_count + 61'd1;
              fill_pos   <= fill_pos + 6'd1;
            end
            if (s_tuser && fill_pos == 6'd63) begin
              state     <= S_ROUND;
              ret_state <= s_tlast ? S_PAD80 : S_IDLE;
            end else if (s_tlast) begin
              state <= S_PAD80;
            end
          end
        end
        S_PAD80: begin
          fill_pos <= fill_pos + 6'd1;
          // The length fits in this block only if the marker lands before byte 56.
          len_arm  <= (fill_pos < 6'd56) || (fill_pos == 6'd63);
          if (fill_pos == 6'd63) begin
            state     <= S_ROUND;
            ret_state <= S_PADZ;
          end else begin
            state <= S_PADZ;
          end
        end
        S_PADZ: begin
          if (len_arm && fill_pos == 6'd56) begin
            state <= S_LEN;
          end else begin
            fill_pos <= fill_pos + 6'd1;
            if (fill_pos == 6'd63) begin
              len_arm   <= 1'b1;
              state     <= S_ROUND;
              ret_state <= S_PADZ;
            end
          end
        end
        S_LEN: begin
          fill_pos <= fill_pos + 6'd1;
          if (fill_pos == 6'd63) begin
            state     <= S_ROUND;
            ret_state <= S_OUT;
          end
        end
        S_ROUND: begin
          if (round_idx == LAST_ROUND) begin
            round_idx <= 7'd0;
            state     <= S_ADD;
          end else begin
            round_idx <= round_idx + 7'd1;
          end
        end
        S_ADD: begin
          chain[0] <= chain[0] + work.a;
          chain[1] <= chain[1] + work.b;
          chain[2] <= chain[2] + work.c;
          chain[3] <= chain[3] + work.d;
          chain[4] <= chain[4] + work.e;
          state    <= ret_state;
        end
        S_OUT: begin
          // Wait for the output buffer to drain, then hand over the digest.
          if (out_left == 3'd0) begin
            out_left   <= 3'd5;
            byte_count <= 61'd0;
            len_arm    <= 1'b0;
            state      <= S_IDLE;
            for (int i = 0; i < 5; i++) begin
              chain[i] <= H_INIT[i];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "sha1_message_digest_assert.svh"

  `SHA1MD_ASSERT_NOW(a_round_bound, state == S_ROUND, round_idx <= LAST_ROUND, "round overrun")
  `SHA1MD_ASSERT_NEXT(a_round_done, round_idx == LAST_ROUND, state == S_ADD, "no add after rounds")
  `SHA1MD_ASSERT_NEXT(a_load, state == S_OUT && !m_tvalid, out_left == 3'd5, "digest not loaded")
  `SHA1MD_ASSERT_NEXT(a_last_gap, m_tvalid && m_tready && m_tlast, !m_tvalid, "beat after last")

endmodule

`default_nettype wire

>>> rtl/sha1md_round.sv
// One SHA-1 round: the shared unit the sequencer steps through eighty times per block.
`default_nettype none

module sha1md_round import sha1md_pkg::*; (
  input  round_words_t cur,
  input  logic [31:0]  w,
  input  logic [6:0]   round_idx,
  output round_words_t nxt
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    if (round_idx inside {[7'd0:7'd19]}) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = K_0;
    end else if (round_idx inside {[7'd20:7'd39]}) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K_1;
    end else if (round_idx inside {[7'd40:7'd59]}) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = K_2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K_3;
    end
  end

  assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;

  assign nxt.a = t;
  assign nxt.b = cur.a;
  assign nxt.c = {cur.b[1:0], cur.b[31:2]};
  assign nxt.d = cur.c;
  assign nxt.e = cur.d;

endmodule

`default_nettype wire

>>> tb/sha1_message_digest_test.sv
// Self-checking testbench for the byte-serial SHA-1 digest engine.
`timescale 1ns / 100ps

module sha1_message_digest_test import sha1md_pkg::*;;

  // Run-length guard.
  localparam int CYCLE_LIMIT = 400000;
  // Message beats with a byte or a close that the stimulus aims for.
  localparam int TARGET_BEATS = 500;
  // Cycles allowed after the last digest word.
  localparam int DRAIN_CYCLES = 250;

  // Golden SHA-1 model plus the queue of digest words it has predicted.
  class sha1_digest_book;
    bit [31:0] chain[5];
    bit [31:0] block_words[16];
    bit [60:0] byte_count;
    bit [31:0] expected_words[$];
    bit        expected_last[$];
    int        fails;

    function new();
      restart();
      fails = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 5; i++) chain[i] = H_INIT[i];
      byte_count = '0;
    endfunction

    function void put_byte(int pos, bit [7:0] b);
      block_words[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = b;
    endfunction

    // One 64-byte block through the 80 rounds, added into the chaining words.
    function void compress();
      bit [31:0] sched[80];
      bit [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) sched[i] = block_words[i];
      for (int i = 16; i < 80; i++) begin
        x = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
        sched[i] = {x[30:0], x[31]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = K_0;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = K_1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = K_2;
        end else begin
          f = b ^ c ^ d; k = K_3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + sched[i];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    // Called for every accepted input beat.
    function void note_beat(bit [7:0] data, bit has_byte, bit end_of_message);
      int pos;
      bit [63:0] bit_len;
      if (has_byte) begin
        pos = int'(byte_count[5:0]);
        put_byte(pos, data);
        byte_count = byte_count + 1'b1;
        if (pos == 63) compress();
      end
      if (end_of_message) begin
        pos = int'(byte_count[5:0]);
        bit_len = {byte_count, 3'b000};
        put_byte(pos, PAD_BYTE);
        for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
        // No room for the length: finish this block, then a block of zeros plus length.
        if (pos >= 56) begin
          compress();
          for (int i = 0; i < 16; i++) block_words[i] = '0;
        end
        block_words[14] = bit_len[63:32];
        block_words[15] = bit_len[31:0];
        compress();
        for (int i = 0; i < 5; i++) begin
          expected_words = {expected_words, chain[i]};
          expected_last  = {expected_last, bit'(i == 4)};
        end
        restart();
      end
    endfunction

    // Called for every accepted digest word.
    function void check_word(bit [31:0] digest_word, bit word_last);
      bit [31:0] want_word;
      bit        want_last;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected digest word %h (word_last %0b)", $time, digest_word,
                 word_last);
        fails++;
        return;
      end
      want_word = expected_words.pop_front();
      want_last = expected_last.pop_front();
      if (digest_word !== want_word) begin
        $display("%0t: digest_word expected %h actual %h", $time, want_word, digest_word);
        fails++;
      end
      if (word_last !== want_last) begin
        $display("%0t: word_last expected %0b actual %0b", $time, want_last, word_last);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tuser;   // [0] has_byte
  logic        s_tlast;   // end_of_message
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] digest_word
  logic        m_tlast;   // word_last

  sha1_digest_book book;
  int          cycle_count = 0;
  int          message_beats;   // accepted beats carrying a byte or a close
  bit          steady;          // when set, neither side inserts idle cycles

  sha1_message_digest u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop in case the engine hangs or loses a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sha1_message_digest_test failed");
      $finish;
    end
  end

  // Receiver side: backpressure about 28 percent of cycles, none while steady is set.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 28);
    end
  end

  // Result monitor. Values read here are the ones the engine sampled at this edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_word(m_tdata, m_tlast);
  end

  // Drive one input beat and hold it until accepted. Starts and ends on a rising edge,
  // so back-to-back beats keep s_tvalid high without lowering it in between.
  task automatic send_beat(bit [7:0] data, bit has_byte, bit end_of_message);
    while (!steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= has_byte;
    s_tlast  <= end_of_message;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_beat(data, has_byte, end_of_message);
    if (has_byte || end_of_message) message_beats++;
  endtask

  // A message of random bytes. It is closed either on its last byte or by a separate
  // byte-less close beat; now and then an ignored beat (no byte, no close) slips in.
  task automatic send_message(int len);
    bit close_on_byte;
    close_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    int pick;
    book          = new();
    message_beats = 0;
    steady        = 1'b0;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    s_tlast       = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, an ignored beat, "abc" closed on its last byte,
    // the byte extremes closed by a byte-less close, and a lone byte with close.
    send_beat(8'h5A, 1'b0, 1'b1);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);

    // Random messages. Most are short; many land near the padding boundaries where the
    // length does or does not fit in the final block (55/56 and 63/64 bytes), and a few
    // span two blocks.
    while (message_beats < TARGET_BEATS) begin
      steady = (message_beats >= 200) && (message_beats < 320);
      pick = $urandom_range(99);
      if (pick < 50) len = $urandom_range(12);
      else if (pick < 78) len = $urandom_range(72, 52);
      else if (pick < 92) len = $urandom_range(140);
      else len = $urandom_range(130, 115);
      send_message(len);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    while (book.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.fails == 0) begin
      $display("sha1_message_digest_test passed");
    end else begin
      $display("sha1_message_digest_test failed");
    end
    $finish;
  end

endmodule
